### sv/etf_pkg.sv
`default_nettype none

package etf_pkg;

  parameter int unsigned QUEUE_DEPTH_DEF = 16;

  localparam logic [15:0] TTL_RESET = 16'd7;

  // input item kinds
  localparam logic [1:0] KIND_BADGE = 2'd0;
  localparam logic [1:0] KIND_CROSS = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result event kinds
  localparam logic [2:0] EV_EXPIRED    = 3'd0;
  localparam logic [2:0] EV_CREATED    = 3'd1;
  localparam logic [2:0] EV_AUTHORIZED = 3'd2;
  localparam logic [2:0] EV_ALARM      = 3'd3;
  localparam logic [2:0] EV_TICK       = 3'd4;

  typedef struct packed {
    logic [31:0] badge;
    logic [7:0]  source;
    logic [31:0] expiry;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINAL,
    ST_AUTH_RD,
    ST_AUTH
  } state_t;

endpackage

`default_nettype wire

### sv/etf_if.sv
`default_nettype none

interface etf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] badge_number;
  logic [7:0]  source_code;

  modport source (output valid, kind, badge_number, source_code, input ready);
  modport sink   (input valid, kind, badge_number, source_code, output ready);
endinterface

interface etf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_badge;
  logic [7:0]  event_source;
  logic [4:0]  token_total;
  logic        last;

  modport source (output valid, event_kind, event_badge, event_source, token_total, last,
                  input ready);
  modport sink   (input valid, event_kind, event_badge, event_source, token_total, last,
                  output ready);
endinterface

`default_nettype wire

### sv/etf_ram.sv
`default_nettype none

module etf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/expiring_token_fifo_unit.sv
// Ordered queue of expiring access tokens held in one single-port-read RAM
// as a ring (head pointer plus count). A badge read appends a token,
// dropping the oldest when full. A crossing or a tick walks the held
// tokens through the RAM read port in order, emitting an expired event
// for each expired token and writing survivors back compacted. A crossing
// then reads and removes the head token as authorized, or raises an alarm
// when no token is left; a tick ends with a tick event. Results pass
// through one output register, so a new item is accepted while the last
// result still waits.
// The RAM contents are not cleared by reset; only entries below the count
// are ever read. ttl writes are taken at any time but must occur while idle.
`default_nettype none

module expiring_token_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = etf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  etf_in_if.sink           in_ch,
  etf_out_if.source        out_ch
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TOK_W = $bits(etf_pkg::token_t);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [4:0] to_total(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] t;
    t = {5'd0, c};
    return t[4:0];
  endfunction

  etf_pkg::state_t state_r, state_nxt;

  logic [1:0]       kind_r, kind_nxt;
  logic [31:0]      badge_r, badge_nxt;
  logic [7:0]       src_r, src_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_k_r, scan_k_nxt;
  logic [CNT_W-1:0] scan_j_r, scan_j_nxt;
  logic [CNT_W-1:0] scan_n_r, scan_n_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [15:0]      ttl_r, ttl_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_kind_r, out_kind_nxt;
  logic [31:0]      out_badge_r, out_badge_nxt;
  logic [7:0]       out_src_r, out_src_nxt;
  logic [4:0]       out_total_r, out_total_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  etf_pkg::token_t  ram_wtok, rd_tok;
  logic [TOK_W-1:0] ram_rdata;

  logic             out_free, out_load, in_acc, tok_expired, drop_oldest;
  logic [31:0]      age;
  logic [IDX_W-1:0] add_head;
  logic [CNT_W-1:0] add_cnt;

  etf_ram #(
    .WIDTH (TOK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_token_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wtok),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_tok      = etf_pkg::token_t'(ram_rdata);
  assign age         = now_r - rd_tok.expiry;
  assign tok_expired = ~age[31];
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign drop_oldest = (cnt_r == DEPTH_C);
  assign add_head    = drop_oldest ? wrap_add(head_r, IDX_W'(1)) : head_r;
  assign add_cnt     = drop_oldest ? cnt_r - CNT_W'(1) : cnt_r;

  assign in_ch.ready         = (state_r == etf_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.event_badge  = out_badge_r;
  assign out_ch.event_source = out_src_r;
  assign out_ch.token_total  = out_total_r;
  assign out_ch.last         = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      etf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.kind)
            etf_pkg::KIND_BADGE: state_nxt = etf_pkg::ST_ADD;
            etf_pkg::KIND_CROSS,
            etf_pkg::KIND_TICK:  state_nxt = etf_pkg::ST_SCAN_RD;
            default:             state_nxt = etf_pkg::ST_FINAL;
          endcase
        end
      end
      etf_pkg::ST_ADD: begin
        if (out_free) state_nxt = etf_pkg::ST_IDLE;
      end
      etf_pkg::ST_SCAN_RD: begin
        state_nxt = (scan_k_r == scan_n_r) ? etf_pkg::ST_FINAL : etf_pkg::ST_SCAN_CHK;
      end
      etf_pkg::ST_SCAN_CHK: begin
        if (!tok_expired || out_free) state_nxt = etf_pkg::ST_SCAN_RD;
      end
      etf_pkg::ST_FINAL: begin
        if (kind_r == etf_pkg::KIND_CROSS && cnt_r != '0) begin
          state_nxt = etf_pkg::ST_AUTH_RD;
        end else if (out_free) begin
          state_nxt = etf_pkg::ST_IDLE;
        end
      end
      etf_pkg::ST_AUTH_RD: state_nxt = etf_pkg::ST_AUTH;
      etf_pkg::ST_AUTH: begin
        if (out_free) state_nxt = etf_pkg::ST_IDLE;
      end
      default: state_nxt = etf_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory port and result register
  always_comb begin
    kind_nxt      = kind_r;
    badge_nxt     = badge_r;
    src_nxt       = src_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    scan_k_nxt    = scan_k_r;
    scan_j_nxt    = scan_j_r;
    scan_n_nxt    = scan_n_r;
    now_nxt       = now_r;
    ttl_nxt       = cfg_wr_en ? cfg_wr_data : ttl_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = '0;
    ram_wtok      = rd_tok;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_badge_nxt = out_badge_r;
    out_src_nxt   = out_src_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      etf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt   = in_ch.kind;
          badge_nxt  = in_ch.badge_number;
          src_nxt    = in_ch.source_code;
          scan_k_nxt = '0;
          scan_j_nxt = '0;
          scan_n_nxt = cnt_r;
          if (in_ch.kind == etf_pkg::KIND_TICK) now_nxt = now_r + 32'd1;
        end
      end
      etf_pkg::ST_ADD: begin
        if (out_free) begin
          // drop the oldest silently when full, then append at the tail
          ram_we          = 1'b1;
          ram_waddr       = wrap_add(add_head, add_cnt[IDX_W-1:0]);
          ram_wtok.badge  = badge_r;
          ram_wtok.source = src_r;
          ram_wtok.expiry = now_r + {16'd0, ttl_r};
          head_nxt        = add_head;
          cnt_nxt         = add_cnt + CNT_W'(1);
          out_load        = 1'b1;
          out_kind_nxt    = etf_pkg::EV_CREATED;
          out_badge_nxt   = badge_r;
          out_src_nxt     = src_r;
          out_total_nxt   = to_total(add_cnt + CNT_W'(1));
          out_last_nxt    = 1'b1;
        end
      end
      etf_pkg::ST_SCAN_RD: begin
        if (scan_k_r != scan_n_r) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_r, scan_k_r[IDX_W-1:0]);
        end
      end
      etf_pkg::ST_SCAN_CHK: begin
        if (tok_expired) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_kind_nxt  = etf_pkg::EV_EXPIRED;
            out_badge_nxt = rd_tok.badge;
            out_src_nxt   = rd_tok.source;
            out_total_nxt = to_total(cnt_r - CNT_W'(1));
            out_last_nxt  = 1'b0;
            cnt_nxt       = cnt_r - CNT_W'(1);
            scan_k_nxt    = scan_k_r + CNT_W'(1);
          end
        end else begin
          // keep: compact toward the head
          ram_we     = 1'b1;
          ram_waddr  = wrap_add(head_r, scan_j_r[IDX_W-1:0]);
          scan_j_nxt = scan_j_r + CNT_W'(1);
          scan_k_nxt = scan_k_r + CNT_W'(1);
        end
      end
      etf_pkg::ST_FINAL: begin
        if (!(kind_r == etf_pkg::KIND_CROSS && cnt_r != '0) && out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = (kind_r == etf_pkg::KIND_CROSS) ? etf_pkg::EV_ALARM
                                                          : etf_pkg::EV_TICK;
          out_badge_nxt = '0;
          out_src_nxt   = src_r;
          out_total_nxt = to_total(cnt_r);
          out_last_nxt  = 1'b1;
        end
      end
      etf_pkg::ST_AUTH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
      end
      etf_pkg::ST_AUTH: begin
        if (out_free) begin
          head_nxt      = wrap_add(head_r, IDX_W'(1));
          cnt_nxt       = cnt_r - CNT_W'(1);
          out_load      = 1'b1;
          out_kind_nxt  = etf_pkg::EV_AUTHORIZED;
          out_badge_nxt = rd_tok.badge;
          out_src_nxt   = src_r;
          out_total_nxt = to_total(cnt_r - CNT_W'(1));
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_load | (out_valid_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= etf_pkg::ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      now_r       <= '0;
      ttl_r       <= etf_pkg::TTL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      ttl_r       <= ttl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    badge_r     <= badge_nxt;
    src_r       <= src_nxt;
    scan_k_r    <= scan_k_nxt;
    scan_j_r    <= scan_j_nxt;
    scan_n_r    <= scan_n_nxt;
    out_kind_r  <= out_kind_nxt;
    out_badge_r <= out_badge_nxt;
    out_src_r   <= out_src_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("token count above queue depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != etf_pkg::ST_IDLE)
    else $error("accepted transfer did not start work");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("read and write issued in the same cycle");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == etf_pkg::ST_SCAN_CHK |-> scan_j_r <= scan_k_r && scan_k_r < scan_n_r)
    else $error("compaction write pointer passed read pointer");

  a_grow_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == etf_pkg::ST_ADD && out_free |=> cnt_r != '0)
    else $error("append left the queue empty");

endmodule

`default_nettype wire
